[hdl/tmor_pkg.sv]
package tmor_pkg;

  localparam int MAX_OPTION_BYTES_DEF = 40;

  localparam logic [7:0] OPT_EOL     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] MSS_OPT_LEN = 8'd4;
  localparam logic [7:0] MIN_OPT_LEN = 8'd2;

  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [5:0] {
    PH_KIND   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_MSS_HI = 6'b001000,
    PH_MSS_LO = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       changed;
  } res_t;

  // up to two result beats produced by one input beat
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

[hdl/tmor_parser.sv]
module tmor_parser import tmor_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  opt_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        is_tcp_syn,
  input  logic [15:0] reduce_by,
  output push_t       push
);

  localparam logic [7:0] MaxLen = 8'(MAX_OPTION_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic        mss_kind_r, mss_kind_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        active_r, active_nxt;
  logic [15:0] red_r, red_nxt;

  always_comb begin
    logic [15:0] mss;
    logic        chg;
    res_t        slot [2];
    logic [1:0]  n;
    logic [5:0]  skip_dec;

    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    mss_kind_nxt = mss_kind_r;
    held_nxt     = held_r;
    active_nxt   = active_r;
    red_nxt      = red_r;
    slot[0]      = '0;
    slot[1]      = '0;
    n            = 2'd0;
    mss          = {held_r, opt_byte};
    chg          = 1'b0;
    skip_dec     = skip_r - 6'd1;

    if (first_byte) begin
      // held high byte with no low byte: flush it untouched
      if (active_r && phase_r == PH_MSS_LO) begin
        slot[0] = '{data: held_r, last: 1'b0, changed: 1'b0};
        n = 2'd1;
      end
      active_nxt   = is_tcp_syn;
      red_nxt      = reduce_by;
      phase_nxt    = PH_KIND;
      skip_nxt     = '0;
      mss_kind_nxt = 1'b0;
      held_nxt     = '0;
    end

    if (!active_nxt) begin
      slot[n[0]] = '{data: opt_byte, last: last_byte, changed: 1'b0};
      n = n + 2'd1;
    end else begin
      case (phase_nxt)
        PH_KIND: begin
          if (opt_byte == OPT_EOL) begin
            phase_nxt = PH_DONE;
          end else if (opt_byte != OPT_NOP) begin
            mss_kind_nxt = (opt_byte == OPT_MSS);
            phase_nxt = PH_LEN;
          end
          slot[n[0]] = '{data: opt_byte, last: last_byte, changed: 1'b0};
          n = n + 2'd1;
        end
        PH_LEN: begin
          if (mss_kind_nxt && opt_byte == MSS_OPT_LEN) begin
            phase_nxt = PH_MSS_HI;
          end else if (opt_byte < MIN_OPT_LEN || opt_byte > MaxLen) begin
            phase_nxt = PH_DONE;
          end else begin
            skip_nxt = 6'(opt_byte - MIN_OPT_LEN);
            phase_nxt = (opt_byte == MIN_OPT_LEN) ? PH_KIND : PH_SKIP;
          end
          slot[n[0]] = '{data: opt_byte, last: last_byte, changed: 1'b0};
          n = n + 2'd1;
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 6'd0) begin
            phase_nxt = PH_KIND;
          end
          slot[n[0]] = '{data: opt_byte, last: last_byte, changed: 1'b0};
          n = n + 2'd1;
        end
        PH_MSS_HI: begin
          if (last_byte) begin
            slot[n[0]] = '{data: opt_byte, last: 1'b1, changed: 1'b0};
            n = n + 2'd1;
          end else begin
            held_nxt  = opt_byte;
            phase_nxt = PH_MSS_LO;
          end
        end
        PH_MSS_LO: begin
          if (mss > red_nxt) begin
            mss = mss - red_nxt;
            chg = 1'b1;
          end
          slot[0] = '{data: mss[15:8], last: 1'b0, changed: chg};
          slot[1] = '{data: mss[7:0], last: last_byte, changed: chg};
          n = 2'd2;
          phase_nxt = PH_DONE;
        end
        default: begin
          slot[n[0]] = '{data: opt_byte, last: last_byte, changed: 1'b0};
          n = n + 2'd1;
        end
      endcase
    end

    if (last_byte) begin
      active_nxt   = 1'b0;
      phase_nxt    = PH_KIND;
      skip_nxt     = '0;
      mss_kind_nxt = 1'b0;
      held_nxt     = '0;
    end

    push.n  = acc ? n : 2'd0;
    push.r0 = slot[0];
    push.r1 = slot[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_KIND;
      skip_r     <= '0;
      mss_kind_r <= 1'b0;
      held_r     <= '0;
      active_r   <= 1'b0;
      red_r      <= '0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      mss_kind_r <= mss_kind_nxt;
      held_r     <= held_nxt;
      active_r   <= active_nxt;
      red_r      <= red_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a beat that yields nothing is always a held MSS high byte
  a_silent_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && push.n == 2'd0) |=> (phase_r == PH_MSS_LO))
    else $error("silent beat without held MSS high byte");

  // the rewritten low byte never comes without its high byte rewritten
  a_chg_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2 && push.r1.changed) |-> push.r0.changed)
    else $error("changed low byte without changed high byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_byte) |=> (!active_r && phase_r == PH_KIND))
    else $error("walk state not cleared after last beat");
`endif

endmodule

[hdl/tmor_outq.sv]
module tmor_outq import tmor_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_changed
);

  localparam int PtrW = $clog2(OUTQ_DEPTH);
  localparam int CntW = $clog2(OUTQ_DEPTH + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(OUTQ_DEPTH - 2);

  res_t mem [OUTQ_DEPTH];

  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pop;
  res_t            head;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign head      = mem[rd_r];
  assign out_byte    = head.data;
  assign out_last    = head.last;
  assign out_changed = head.changed;
  // room for a full two-beat push
  assign room = (cnt_r <= RoomMax);

  always_comb begin
    wr_nxt  = wr_r + PtrW'(push.n);
    rd_nxt  = rd_r + PtrW'(pop);
    cnt_nxt = cnt_r + CntW'(push.n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_r + PtrW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> room)
    else $error("push into queue without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(OUTQ_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CntW'(OUTQ_DEPTH)) |-> (PtrW'(wr_r - rd_r) == PtrW'(cnt_r)))
    else $error("queue pointers disagree with count");
`endif

endmodule

[hdl/tcp_mss_option_reducer_top.sv]
// channel  direction  handshake             payload
// in_      input      in_valid/in_ready     in_opt_byte, in_first_byte, in_last_byte,
//                                           in_is_tcp_syn, in_reduce_by
// out_     output     out_valid/out_ready   out_byte, out_last, out_changed
//
// One input beat per cycle while in_ready is high; the options parser updates its state
// in the accepting cycle and pushes 0, 1 or 2 result beats into a 4-entry queue.
// A result is registered in the queue and can be taken in the cycle after its input beat at the earliest.
// in_ready drops only when the queue lacks room for two beats.
// rst_n is synchronous, active low, and empties the queue and the walk state.
module tcp_mss_option_reducer_top import tmor_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        in_is_tcp_syn,
  input  logic [15:0] in_reduce_by,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_changed
);

  push_t push;
  logic  room;
  logic  acc;

  assign in_ready = room;
  assign acc      = in_valid && room;

  tmor_parser #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .opt_byte   (in_opt_byte),
    .first_byte (in_first_byte),
    .last_byte  (in_last_byte),
    .is_tcp_syn (in_is_tcp_syn),
    .reduce_by  (in_reduce_by),
    .push       (push)
  );

  tmor_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_changed (out_changed)
  );

endmodule

[tb/tb_tcp_mss_option_reducer_top.sv]
`timescale 1ns / 100ps

module tb_tcp_mss_option_reducer_top;
  import tmor_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEM_TARGET = 1000;

  typedef struct packed {
    logic [7:0]  b;
    logic        first;
    logic        last;
    logic        syn;
    logic [15:0] red;
  } opt_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_opt_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        in_is_tcp_syn = 1'b0;
  logic [15:0] in_reduce_by = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_changed;

  tcp_mss_option_reducer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opt_byte  (in_opt_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .in_is_tcp_syn(in_is_tcp_syn),
    .in_reduce_by (in_reduce_by),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_changed  (out_changed)
  );

  opt_beat_t   pending_beats[$];
  res_t        expected_beats[$];
  logic [7:0]  pkt_bytes[$];
  int          beats_outstanding = 0;
  int          items_queued = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          hold_off_left = 0;
  logic        hold_off_req = 1'b0;

  // option walk state, mirrors the block after reset
  phase_t      walk_phase = PH_KIND;
  logic [5:0]  skip_left = '0;
  logic        kind_is_mss = 1'b0;
  logic [7:0]  held_hi = '0;
  logic        walk_active = 1'b0;
  logic [15:0] cut_amount = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void note_beat(input logic [7:0] d, input logic l, input logic c);
    expected_beats.push_back({d, l, c});
  endfunction

  task automatic mss_clamp_predict(input opt_beat_t it);
    logic [15:0] mss;
    logic        chg;
    if (it.first) begin
      // packet restarted without a last mark: flush the held high byte
      if (walk_active && walk_phase == PH_MSS_LO) note_beat(held_hi, 1'b0, 1'b0);
      walk_active = it.syn;
      cut_amount  = it.red;
      walk_phase  = PH_KIND;
      skip_left   = '0;
      kind_is_mss = 1'b0;
      held_hi     = '0;
    end
    if (!walk_active) begin
      note_beat(it.b, it.last, 1'b0);
    end else begin
      case (walk_phase)
        PH_KIND: begin
          if (it.b == OPT_EOL) begin
            walk_phase = PH_DONE;
          end else if (it.b != OPT_NOP) begin
            kind_is_mss = (it.b == OPT_MSS);
            walk_phase  = PH_LEN;
          end
          note_beat(it.b, it.last, 1'b0);
        end
        PH_LEN: begin
          if (kind_is_mss && it.b == MSS_OPT_LEN) begin
            walk_phase = PH_MSS_HI;
          end else if (it.b < MIN_OPT_LEN || it.b > MAX_OPTION_BYTES_DEF) begin
            walk_phase = PH_DONE;
          end else begin
            skip_left  = 6'(it.b - MIN_OPT_LEN);
            walk_phase = (skip_left == 0) ? PH_KIND : PH_SKIP;
          end
          note_beat(it.b, it.last, 1'b0);
        end
        PH_SKIP: begin
          skip_left = skip_left - 6'd1;
          if (skip_left == 0) walk_phase = PH_KIND;
          note_beat(it.b, it.last, 1'b0);
        end
        PH_MSS_HI: begin
          if (it.last) begin
            note_beat(it.b, 1'b1, 1'b0);
          end else begin
            held_hi    = it.b;
            walk_phase = PH_MSS_LO;
          end
        end
        PH_MSS_LO: begin
          mss = {held_hi, it.b};
          chg = (mss > cut_amount);
          if (chg) mss = mss - cut_amount;
          note_beat(mss[15:8], 1'b0, chg);
          note_beat(mss[7:0], it.last, chg);
          walk_phase = PH_DONE;
        end
        default: begin
          note_beat(it.b, it.last, 1'b0);
        end
      endcase
    end
    if (it.last) begin
      walk_active = 1'b0;
      walk_phase  = PH_KIND;
      skip_left   = '0;
      kind_is_mss = 1'b0;
      held_hi     = '0;
    end
  endtask

  // driver: one beat in flight, payload held until accepted
  always @(posedge clk) begin : drive_in
    logic      next_valid;
    opt_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        mss_clamp_predict('{in_opt_byte, in_first_byte, in_last_byte, in_is_tcp_syn,
                            in_reduce_by});
        beats_outstanding = beats_outstanding - 1;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_beats.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        in_opt_byte   <= nxt.b;
        in_first_byte <= nxt.first;
        in_last_byte  <= nxt.last;
        in_is_tcp_syn <= nxt.syn;
        in_reduce_by  <= nxt.red;
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // monitor: checks result beats, drives out_ready, owns the timeout
  always @(posedge clk) begin : watch_out
    res_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL tcp_mss_option_reducer_top");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: out_byte %02h out_last %0b out_changed %0b",
                 out_byte, out_last, out_changed);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
          if (out_changed !== want.changed) begin
            $error("out_changed: expected %0b, got %0b", want.changed, out_changed);
            fail_count++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_left = HOLD_OFF_CYCLES;
        hold_off_req  = 1'b0;
      end
      if (hold_off_left != 0) begin
        hold_off_left = hold_off_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic first, input logic last,
                           input logic syn, input logic [15:0] red);
    pending_beats.push_back('{b, first, last, syn, red});
    beats_outstanding = beats_outstanding + 1;
    items_queued++;
  endtask

  // sends pkt_bytes; syn and amount only matter on the first byte
  task automatic send_packet(input logic syn, input logic [15:0] red,
                             input logic with_first, input logic with_last);
    int n;
    n = pkt_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        push_beat(pkt_bytes[i], with_first, with_last && n == 1, syn, red);
      end else begin
        push_beat(pkt_bytes[i], 1'b0, with_last && i == n - 1, 1'($urandom),
                  16'($urandom));
      end
    end
    pkt_bytes.delete();
  endtask

  task automatic add_filler_option();
    int len;
    if ($urandom_range(1) == 0) begin
      pkt_bytes.push_back(OPT_NOP);
    end else begin
      len = ($urandom_range(7) == 0) ? MAX_OPTION_BYTES_DEF : $urandom_range(2, 8);
      pkt_bytes.push_back(8'($urandom_range(3, 255)));
      pkt_bytes.push_back(8'(len));
      repeat (len - 2) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic gen_clean_packet();
    logic [15:0] mss;
    logic [15:0] red;
    mss = 16'($urandom);
    case ($urandom_range(7))
      0:       red = 16'h0000;
      1:       red = 16'hFFFF;
      2:       red = mss;
      3:       red = mss - 16'd1;
      4:       red = mss + 16'd1;
      default: red = 16'($urandom);
    endcase
    repeat ($urandom_range(0, 3)) add_filler_option();
    if ($urandom_range(9) != 0) begin
      pkt_bytes.push_back(OPT_MSS);
      pkt_bytes.push_back(MSS_OPT_LEN);
      pkt_bytes.push_back(mss[15:8]);
      pkt_bytes.push_back(mss[7:0]);
    end
    repeat ($urandom_range(0, 2)) add_filler_option();
    if ($urandom_range(1) == 1) begin
      pkt_bytes.push_back(OPT_EOL);
      repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
    end
    if (pkt_bytes.size() == 0) pkt_bytes.push_back(OPT_NOP);
    send_packet($urandom_range(99) < 85, red, 1'b1, 1'b1);
  endtask

  task automatic gen_broken_packet();
    logic       syn;
    logic [7:0] len;
    syn = ($urandom_range(99) < 85);
    repeat ($urandom_range(0, 2)) add_filler_option();
    case ($urandom_range(4))
      0, 1: begin
        // MSS cut off by the last mark, or packet left open
        pkt_bytes.push_back(OPT_MSS);
        pkt_bytes.push_back(MSS_OPT_LEN);
        pkt_bytes.push_back(8'($urandom));
        send_packet(syn, 16'($urandom), 1'b1, $urandom_range(1) == 1);
      end
      2: begin
        if ($urandom_range(1) == 1) begin
          pkt_bytes.push_back(OPT_MSS);
          do len = 8'($urandom_range(0, 60)); while (len == MSS_OPT_LEN);
        end else begin
          pkt_bytes.push_back(8'($urandom_range(3, 255)));
          len = ($urandom_range(1) == 1) ? 8'($urandom_range(0, 1))
                                         : 8'($urandom_range(41, 255));
        end
        pkt_bytes.push_back(len);
        repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom));
        send_packet(syn, 16'($urandom), 1'b1, 1'b1);
      end
      3: begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 10))
          push_beat(8'($urandom), $urandom_range(99) < 15, $urandom_range(99) < 15,
                    1'($urandom), 16'($urandom));
      end
      default: begin
        // bytes between packets
        pkt_bytes.delete();
        repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom));
        send_packet(1'($urandom), 16'($urandom), 1'b0, $urandom_range(1) == 1);
      end
    endcase
  endtask

  task automatic wait_idle();
    while (beats_outstanding != 0 || expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int goal);
    send_idle_pct = idle;
    stall_pct     = stall;
    while (items_queued < goal) begin
      if ($urandom_range(3) != 0) gen_clean_packet();
      else gen_broken_packet();
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats
    pkt_bytes = '{OPT_MSS, MSS_OPT_LEN, 8'h05, 8'hB4};
    send_packet(1'b1, 16'h0100, 1'b1, 1'b1);
    pkt_bytes = '{OPT_NOP, OPT_MSS, MSS_OPT_LEN, 8'hFF, 8'hFF, OPT_EOL};
    send_packet(1'b1, 16'hFFFF, 1'b1, 1'b1);
    pkt_bytes = '{OPT_MSS, MSS_OPT_LEN, 8'h12, 8'h34};
    send_packet(1'b0, 16'h0001, 1'b1, 1'b1);
    pkt_bytes = '{OPT_MSS, 8'h03, 8'hAA, OPT_EOL};
    send_packet(1'b1, 16'h0000, 1'b1, 1'b1);
    pkt_bytes = '{8'h22, 8'h01};
    send_packet(1'b1, 16'h0000, 1'b1, 1'b1);
    pkt_bytes = '{8'h22, 8'd41};
    send_packet(1'b1, 16'h0000, 1'b1, 1'b1);
    pkt_bytes = '{OPT_MSS, MSS_OPT_LEN, 8'h80};
    send_packet(1'b1, 16'h0001, 1'b1, 1'b1);
    pkt_bytes = '{OPT_MSS, MSS_OPT_LEN, 8'h80};
    send_packet(1'b1, 16'h0001, 1'b1, 1'b0);
    pkt_bytes = '{8'hFF};
    send_packet(1'b0, 16'hFFFF, 1'b1, 1'b1);
    pkt_bytes = '{8'h00, 8'hFF};
    send_packet(1'b1, 16'h0000, 1'b0, 1'b0);
    wait_idle();

    run_random_phase(0, 0, items_queued + ITEM_TARGET / 4);
    run_random_phase(78, 0, items_queued + ITEM_TARGET / 4);
    run_random_phase(0, 78, items_queued + ITEM_TARGET / 4);
    run_random_phase(15, 15, items_queued + ITEM_TARGET / 4);

    // long receiver hold-off while the sender keeps offering beats
    hold_off_req = 1'b1;
    run_random_phase(0, 0, items_queued + 60);

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("PASS tcp_mss_option_reducer_top");
    end else begin
      $display("FAIL tcp_mss_option_reducer_top");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tmor_pkg.sv
hdl/tmor_parser.sv
hdl/tmor_outq.sv
hdl/tcp_mss_option_reducer_top.sv
tb/tb_tcp_mss_option_reducer_top.sv
